// ===== design/est_pkg.sv =====
// Shared types and constants for the encoder setpoint thermostat.
// Used by est_front, est_queue, est_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package est_pkg;

  // Operation codes carried on the op field
  typedef enum logic [1:0] {
    OP_ENC     = 2'd0,
    OP_BTN     = 2'd1,
    OP_SENSOR  = 2'd2,
    OP_RESTORE = 2'd3
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_CEILING = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_FLOOR    = 2'd1;

  // Reset values
  localparam logic [7:0] HIGH_CEILING_RST = 8'd100;
  localparam logic [7:0] LOW_FLOOR_RST    = 8'd40;
  localparam logic [7:0] HIGH_SET_RST     = 8'd100;
  localparam logic [7:0] LOW_SET_RST      = 8'd40;

  // Sensor scaling: F = 9*raw/80 + 32, the /5 done as *6554 >> 15
  localparam logic [13:0] DIV5_RECIP  = 14'd6554;
  localparam int unsigned DIV5_SHIFT  = 15;
  localparam logic [8:0]  F_OFFSET    = 9'd32;
  localparam logic [7:0]  TEMP_MAX    = 8'd255;

  // Tens digit of a value below 100 as *205 >> 11
  localparam logic [7:0]  DIV10_RECIP = 8'd205;

  // Report characters
  localparam logic [7:0] CH_START = 8'h40;  // '@'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_END   = 8'h24;  // '$'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  // Report slots in send order
  localparam logic [2:0] SLOT_START = 3'd0;
  localparam logic [2:0] SLOT_PLUS  = 3'd1;
  localparam logic [2:0] SLOT_HUND  = 3'd2;
  localparam logic [2:0] SLOT_TENS  = 3'd3;
  localparam logic [2:0] SLOT_ONES  = 3'd4;
  localparam logic [2:0] SLOT_END   = 3'd5;

  // Queue geometry
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Work for the back end: state snapshot after the item, and report flag
  typedef struct packed {
    logic       report;
    logic [7:0] high_set;
    logic [7:0] low_set;
    logic [7:0] temp;
  } desc_t;

endpackage

`default_nettype wire

// ===== design/est_front.sv =====
// Front end: accepts items, owns the thermostat state and config registers,
// and pushes one descriptor per item into the queue. Depends on est_pkg.
`timescale 1ns / 1ps
`default_nettype none

module est_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [est_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                 cfg_data_i,
  input  wire logic                       accept_i,
  input  wire logic [1:0]                 op_i,
  input  wire logic                       enc_a_i,
  input  wire logic                       enc_b_i,
  input  wire logic                       press_low_i,
  input  wire logic                       press_high_i,
  input  wire logic [7:0]                 sensor_low_byte_i,
  input  wire logic [7:0]                 sensor_high_byte_i,
  input  wire logic [7:0]                 restore_high_i,
  input  wire logic [7:0]                 restore_low_i,
  output est_pkg::desc_t                  desc_o
);

  logic [7:0] high_ceiling_q, low_floor_q;
  logic [1:0] phase_q, phase_d;
  logic       edit_high_q, edit_high_d;
  logic [7:0] high_set_q, high_set_d;
  logic [7:0] low_set_q, low_set_d;
  logic [7:0] temp_q, temp_d;
  logic [7:0] reported_q, reported_d;
  logic       report;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_ceiling_q <= est_pkg::HIGH_CEILING_RST;
      low_floor_q    <= est_pkg::LOW_FLOOR_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == est_pkg::CFG_HIGH_CEILING) high_ceiling_q <= cfg_data_i;
      if (cfg_index_i == est_pkg::CFG_LOW_FLOOR)    low_floor_q    <= cfg_data_i;
    end
  end

  // Decode the Gray-coded encoder sample into a binary phase and a step direction
  logic [1:0] ph;
  logic       step_fwd, step_bwd;
  assign ph       = {enc_b_i, enc_a_i ^ enc_b_i};
  assign step_fwd = (ph == phase_q + 2'd1);
  assign step_bwd = (ph == phase_q - 2'd1);

  // Step the selected setpoint and clamp it
  logic signed [9:0] hv_sum, lv_sum, hv_c, lv_c;
  logic signed [9:0] delta;
  always_comb begin
    delta  = step_fwd ? 10'sd1 : -10'sd1;
    hv_sum = $signed({2'b00, high_set_q}) + delta;
    lv_sum = $signed({2'b00, low_set_q}) + delta;
    hv_c   = hv_sum;
    if (hv_c > $signed({2'b00, high_ceiling_q})) hv_c = $signed({2'b00, high_ceiling_q});
    if (hv_c < $signed({2'b00, low_set_q}))      hv_c = $signed({2'b00, low_set_q});
    lv_c   = lv_sum;
    if (lv_c < $signed({2'b00, low_floor_q}))    lv_c = $signed({2'b00, low_floor_q});
    if (lv_c > $signed({2'b00, high_set_q}))     lv_c = $signed({2'b00, high_set_q});
  end

  // Convert sensor reading to Fahrenheit
  logic [10:0] raw;
  logic [14:0] raw9;
  logic [10:0] raw9_div16;
  logic [24:0] div_prod;
  logic [7:0]  quot;
  logic [8:0]  f_sum;
  logic [7:0]  f_val;
  assign raw        = {sensor_high_byte_i[2:0], sensor_low_byte_i};
  assign raw9       = {raw, 3'b000} + {4'b0000, raw};
  assign raw9_div16 = raw9[14:4];
  assign div_prod   = {14'd0, raw9_div16} * {11'd0, est_pkg::DIV5_RECIP};
  assign quot       = div_prod[est_pkg::DIV5_SHIFT+7:est_pkg::DIV5_SHIFT];
  assign f_sum      = {1'b0, quot} + est_pkg::F_OFFSET;
  assign f_val      = f_sum[8] ? est_pkg::TEMP_MAX : f_sum[7:0];

  // Next state per operation
  always_comb begin
    phase_d     = phase_q;
    edit_high_d = edit_high_q;
    high_set_d  = high_set_q;
    low_set_d   = low_set_q;
    temp_d      = temp_q;
    reported_d  = reported_q;
    report      = 1'b0;
    case (est_pkg::op_e'(op_i))
      est_pkg::OP_ENC: begin
        if (step_fwd || step_bwd) begin
          phase_d = ph;
          if (edit_high_q) high_set_d = hv_c[7:0];
          else             low_set_d  = lv_c[7:0];
        end
      end
      est_pkg::OP_BTN: begin
        if (press_low_i)       edit_high_d = 1'b0;
        else if (press_high_i) edit_high_d = 1'b1;
      end
      est_pkg::OP_SENSOR: begin
        temp_d = f_val;
        if (f_val != reported_q) begin
          reported_d = f_val;
          report     = 1'b1;
        end
      end
      est_pkg::OP_RESTORE: begin
        high_set_d = restore_high_i;
        low_set_d  = restore_low_i;
      end
      default: begin
      end
    endcase
  end

  // Commit state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      edit_high_q <= 1'b1;
      high_set_q  <= est_pkg::HIGH_SET_RST;
      low_set_q   <= est_pkg::LOW_SET_RST;
      temp_q      <= 8'd0;
      reported_q  <= 8'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      edit_high_q <= edit_high_d;
      high_set_q  <= high_set_d;
      low_set_q   <= low_set_d;
      temp_q      <= temp_d;
      reported_q  <= reported_d;
    end
  end

  // Descriptor carries the state as it stands after this item
  assign desc_o.report   = report;
  assign desc_o.high_set = high_set_d;
  assign desc_o.low_set  = low_set_d;
  assign desc_o.temp     = temp_d;

endmodule

`default_nettype wire

// ===== design/est_queue.sv =====
// Short descriptor queue between front and back ends.
// Depends on est_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none

module est_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  est_pkg::desc_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           head_valid_o,
  output est_pkg::desc_t head_o
);

  est_pkg::desc_t             mem_q [est_pkg::QDepth];
  logic [est_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [est_pkg::QCntW-1:0]  cnt_q;

  assign full_o       = (cnt_q == est_pkg::QCntW'(est_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/est_back.sv =====
// Back end: expands each descriptor into one to six result items and
// holds them in the output register. Depends on est_pkg.
`timescale 1ns / 1ps
`default_nettype none

module est_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  est_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output logic [7:0]     tx_char_o,
  output logic           tx_valid_o,
  output logic           last_o,
  output logic           cooling_on_o,
  output logic           heating_on_o,
  output logic [7:0]     high_setpoint_out_o,
  output logic [7:0]     low_setpoint_out_o,
  output logic [7:0]     temperature_out_o
);

  logic       out_valid_q;
  logic [7:0] char_q;
  logic       txv_q, last_q, cool_q, heat_q;
  logic [7:0] high_q, low_q, temp_q;
  logic [2:0] k_q;

  // Decimal digits of the temperature
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens, ones;
  always_comb begin
    if (head_i.temp >= 8'd200)      hund = 2'd2;
    else if (head_i.temp >= 8'd100) hund = 2'd1;
    else                            hund = 2'd0;
    rem       = 7'(head_i.temp - 8'(hund) * 8'd100);
    tens_prod = {8'd0, rem} * {7'd0, est_pkg::DIV10_RECIP};
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);
  end

  // Pick the slot for this result: values below 100 skip the hundreds
  logic [2:0] slot;
  logic [7:0] ch;
  logic       is_last;
  always_comb begin
    slot = ((hund == 2'd0) && (k_q >= est_pkg::SLOT_HUND)) ? k_q + 3'd1 : k_q;
    case (slot)
      est_pkg::SLOT_START: ch = est_pkg::CH_START;
      est_pkg::SLOT_PLUS:  ch = est_pkg::CH_PLUS;
      est_pkg::SLOT_HUND:  ch = est_pkg::CH_ZERO + 8'(hund);
      est_pkg::SLOT_TENS:  ch = est_pkg::CH_ZERO + 8'(tens);
      est_pkg::SLOT_ONES:  ch = est_pkg::CH_ZERO + 8'(ones);
      est_pkg::SLOT_END:   ch = est_pkg::CH_END;
      default:             ch = 8'd0;
    endcase
    is_last = head_i.report ? (slot == est_pkg::SLOT_END) : 1'b1;
  end

  logic load;
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && is_last;

  // Walk through the characters of the head descriptor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) k_q <= is_last ? 3'd0 : k_q + 3'd1;
      if (load)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.report ? ch : 8'd0;
      txv_q  <= head_i.report;
      last_q <= is_last;
      cool_q <= head_i.temp > head_i.high_set;
      heat_q <= head_i.temp < head_i.low_set;
      high_q <= head_i.high_set;
      low_q  <= head_i.low_set;
      temp_q <= head_i.temp;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign tx_char_o           = char_q;
  assign tx_valid_o          = txv_q;
  assign last_o              = last_q;
  assign cooling_on_o        = cool_q;
  assign heating_on_o        = heat_q;
  assign high_setpoint_out_o = high_q;
  assign low_setpoint_out_o  = low_q;
  assign temperature_out_o   = temp_q;

  // Character index stays within a six-character report
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= est_pkg::SLOT_END)
    else $error("report index out of range");

  // A non-report descriptor is always taken at its first result
  a_plain_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && !head_i.report) |-> (k_q == 3'd0))
    else $error("plain descriptor mid-report");

  // A popped descriptor leaves a last result in the output register
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && last_q))
    else $error("pop without last result");

  // A result without a character is always the final one
  a_silent_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !txv_q) |-> last_q)
    else $error("silent result not marked last");

endmodule

`default_nettype wire

// ===== design/encoder_set_thermostat_unit.sv =====
// Top level of the encoder setpoint thermostat: front end, descriptor queue
// and back end. Depends on est_pkg, est_front, est_queue and est_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per cycle unless
//   stalled: an encoder or button sample, sensor reading or setpoint restore.
//   Output channel (out_valid_o / out_stall_i) delivers the results. Every
//   item gives one result, except a sensor reading whose temperature differs
//   from the last reported one: it gives five or six report characters
//   ('@', '+', digits, '$'), one per unstalled cycle, last one marked by last_o.
//   With an empty queue an accepted item is written into the queue, then
//   loaded into the output register, from which the receiver takes it.
//   Single-result items flow at one item per cycle while neither channel
//   stalls; a report holds the back end for its five or six characters, sent
//   one per cycle while out_stall_i is low, while the two-entry queue lets
//   the front end keep accepting until it fills.
//   Config port (cfg_valid_i / cfg_ready_o) is always ready; index 0 sets
//   the high ceiling, index 1 the low floor, other indexes are ignored.
//   Reset empties the queue, drops the output valid flag and restores setpoints to
//   100 and 40, temperature to 0, and the edited setpoint to high.
//   While out_stall_i is high the output holds; the queue fills and then
//   in_stall_o rises until the receiver takes results again.
`timescale 1ns / 1ps
`default_nettype none

module encoder_set_thermostat_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [est_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic                        enc_a_i,
  input  wire logic                        enc_b_i,
  input  wire logic                        press_low_i,
  input  wire logic                        press_high_i,
  input  wire logic [7:0]                  sensor_low_byte_i,
  input  wire logic [7:0]                  sensor_high_byte_i,
  input  wire logic [7:0]                  restore_high_i,
  input  wire logic [7:0]                  restore_low_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [7:0]                       tx_char_o,
  output logic                             tx_valid_o,
  output logic                             last_o,
  output logic                             cooling_on_o,
  output logic                             heating_on_o,
  output logic [7:0]                       high_setpoint_out_o,
  output logic [7:0]                       low_setpoint_out_o,
  output logic [7:0]                       temperature_out_o
);

  est_pkg::desc_t front_desc, head_desc;
  logic           q_full, head_valid, pop, accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !q_full;

  // Classify items and update state
  est_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .accept_i           (accept),
    .op_i               (op_i),
    .enc_a_i            (enc_a_i),
    .enc_b_i            (enc_b_i),
    .press_low_i        (press_low_i),
    .press_high_i       (press_high_i),
    .sensor_low_byte_i  (sensor_low_byte_i),
    .sensor_high_byte_i (sensor_high_byte_i),
    .restore_high_i     (restore_high_i),
    .restore_low_i      (restore_low_i),
    .desc_o             (front_desc)
  );

  // Buffer descriptors
  est_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_data_i  (front_desc),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_desc)
  );

  // Emit results
  est_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_i              (head_desc),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .tx_char_o           (tx_char_o),
    .tx_valid_o          (tx_valid_o),
    .last_o              (last_o),
    .cooling_on_o        (cooling_on_o),
    .heating_on_o        (heating_on_o),
    .high_setpoint_out_o (high_setpoint_out_o),
    .low_setpoint_out_o  (low_setpoint_out_o),
    .temperature_out_o   (temperature_out_o)
  );

endmodule

`default_nettype wire
